@@ rtl/core/ltd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd_pkg
// Shared widths and the token record passed from the front to the back of
// the LZ77 token decoder.
// ----------------------------------------------------------------------------
package ltd_pkg;

  localparam int unsigned POS_W  = 12;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;

  // A token after classification: the position is already reduced into the
  // history and the length is already saturated.
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] lit;
  } token_t;

endpackage

@@ rtl/core/ltd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd_front
// Accepts tokens, reduces the match position into the history range,
// saturates the match length and hands the token to the queue.
// ----------------------------------------------------------------------------
module ltd_front #(
  parameter int unsigned HISTORY_DEPTH    = 4096,
  parameter int unsigned MAX_MATCH_LENGTH = 63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ltd_pkg::POS_W-1:0]     match_position_i,
  input  logic [ltd_pkg::LEN_W-1:0]     match_length_i,
  input  logic [ltd_pkg::BYTE_W-1:0]    literal_byte_i,
  output logic                          push_o,
  input  logic                          full_i,
  output ltd_pkg::token_t               token_o
);

  // Number of quotient bits of a position divided by the history depth.
  localparam int unsigned PosMax = (1 << ltd_pkg::POS_W) - 1;
  localparam int unsigned QBits  = (HISTORY_DEPTH > PosMax) ? 0 :
                                   $clog2(PosMax / HISTORY_DEPTH + 1);
  localparam int unsigned StepW  = ltd_pkg::POS_W + 5;

  logic                          valid_q, valid_d;
  ltd_pkg::token_t               token_q;
  logic [ltd_pkg::POS_W-1:0]     pos_red;
  logic [ltd_pkg::LEN_W-1:0]     len_sat;
  logic [StepW-1:0]              step;
  logic                          accept;

  // Restoring reduction: one conditional subtract per quotient bit.
  always_comb begin
    pos_red = match_position_i;
    step    = '0;
    for (int k = int'(QBits) - 1; k >= 0; k--) begin
      step = StepW'(HISTORY_DEPTH) << k;
      if ({{(StepW - ltd_pkg::POS_W){1'b0}}, pos_red} >= step) begin
        pos_red = pos_red - step[ltd_pkg::POS_W-1:0];
      end
    end
  end

  assign len_sat = (match_length_i > ltd_pkg::LEN_W'(MAX_MATCH_LENGTH)) ?
                   ltd_pkg::LEN_W'(MAX_MATCH_LENGTH) : match_length_i;

  assign push_o     = valid_q && !full_i;
  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign token_o    = token_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      token_q.pos <= pos_red;
      token_q.len <= len_sat;
      token_q.lit <= literal_byte_i;
    end
  end

endmodule

@@ rtl/core/ltd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd_queue
// Two-entry token queue that decouples the front from the copy engine.
// ----------------------------------------------------------------------------
module ltd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ltd_pkg::token_t token_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output ltd_pkg::token_t token_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ltd_pkg::token_t   entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign token_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= token_i;
    end
  end

endmodule

@@ rtl/core/ltd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd_back
// Copy engine: reads the history one byte per cycle unless stalled, writes
// every emitted byte back at the write pointer, drives the output register.
// ----------------------------------------------------------------------------
module ltd_back #(
  parameter int unsigned HISTORY_DEPTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  ltd_pkg::token_t             q_token_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ltd_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_of_token_o
);

  localparam int unsigned AddrW = $clog2(HISTORY_DEPTH);

  logic [ltd_pkg::BYTE_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [ltd_pkg::BYTE_W-1:0] rdata_q;

  // Token being worked on.
  logic                        cur_valid_q, cur_valid_d;
  logic [AddrW-1:0]            rd_addr_q, rd_addr_d;
  logic [ltd_pkg::LEN_W-1:0]   remain_q, remain_d;
  logic [ltd_pkg::BYTE_W-1:0]  lit_q;

  // Byte in flight between the history read and the output register.
  logic                        fl_valid_q, fl_valid_d;
  logic                        fl_lit_q;
  logic                        fl_fwd_q;
  logic [ltd_pkg::BYTE_W-1:0]  fl_data_q;
  logic [ltd_pkg::BYTE_W-1:0]  fl_byte;

  logic                        out_valid_q, out_valid_d;
  logic [ltd_pkg::BYTE_W-1:0]  out_byte_q;
  logic                        out_last_q;

  logic [AddrW-1:0]            wp_q, wp_d;

  logic                        move;
  logic                        issue;
  logic                        lit_issue;
  logic                        rd_issue;
  logic                        load;
  logic                        fwd;

  // A read issued at the edge that writes the same entry sees the old value,
  // so the byte being written is forwarded instead.
  assign fl_byte   = (fl_lit_q || fl_fwd_q) ? fl_data_q : rdata_q;
  assign move      = fl_valid_q && (!out_valid_q || !out_stall_i);
  assign issue     = cur_valid_q && (!fl_valid_q || move);
  assign lit_issue = issue && (remain_q == '0);
  assign rd_issue  = issue && (remain_q != '0);
  assign load      = q_valid_i && (!cur_valid_q || lit_issue);
  assign fwd       = move && (rd_addr_q == wp_q);
  assign q_pop_o   = load;

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_of_token_o = out_last_q;

  always_comb begin
    cur_valid_d = cur_valid_q;
    rd_addr_d   = rd_addr_q;
    remain_d    = remain_q;
    fl_valid_d  = fl_valid_q;
    out_valid_d = out_valid_q;
    wp_d        = wp_q;

    if (rd_issue) begin
      rd_addr_d = (rd_addr_q == AddrW'(HISTORY_DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;
      remain_d  = remain_q - 1'b1;
    end
    if (load) begin
      cur_valid_d = 1'b1;
      rd_addr_d   = AddrW'(q_token_i.pos);
      remain_d    = q_token_i.len;
    end else if (lit_issue) begin
      cur_valid_d = 1'b0;
    end

    if (issue) begin
      fl_valid_d = 1'b1;
    end else if (move) begin
      fl_valid_d = 1'b0;
    end

    if (move) begin
      out_valid_d = 1'b1;
      wp_d        = (wp_q == AddrW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      rd_addr_q   <= '0;
      remain_q    <= '0;
      fl_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wp_q        <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      rd_addr_q   <= rd_addr_d;
      remain_q    <= remain_d;
      fl_valid_q  <= fl_valid_d;
      out_valid_q <= out_valid_d;
      wp_q        <= wp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lit_q <= q_token_i.lit;
    end
    if (issue) begin
      fl_lit_q  <= lit_issue;
      fl_fwd_q  <= rd_issue && fwd;
      fl_data_q <= lit_issue ? lit_q : fl_byte;
    end
    if (move) begin
      out_byte_q <= fl_byte;
      out_last_q <= fl_lit_q;
    end
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (move) begin
      hist_mem[wp_q] <= fl_byte;
    end
    if (rd_issue) begin
      rdata_q <= hist_mem[rd_addr_q];
    end
  end

endmodule

@@ rtl/core/lz77_token_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_token_decoder_unit
// LZ77 token decoder: expands position/length/literal tokens into a byte
// stream using an on-chip history memory.
// ----------------------------------------------------------------------------
// Each token of match length L (saturated to MAX_MATCH_LENGTH) produces L
// copied bytes followed by its literal byte, one byte per cycle while the
// output is not stalled; the single-port read and single-port write of the
// history memory set that pace. The front end reduces the position into
// the history and accepts one token per cycle while its two-entry queue
// has room, so the next tokens are taken in while a copy is running.
// Copies may overlap the bytes they produce. The history is not cleared
// after reset; reading an entry never written gives an undefined byte.
module lz77_token_decoder_unit #(
  parameter int unsigned HISTORY_DEPTH    = 4096,
  parameter int unsigned MAX_MATCH_LENGTH = 63
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ltd_pkg::POS_W-1:0]   match_position_i,
  input  logic [ltd_pkg::LEN_W-1:0]   match_length_i,
  input  logic [ltd_pkg::BYTE_W-1:0]  literal_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ltd_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_of_token_o
);

  logic            push;
  logic            full;
  logic            q_valid;
  logic            q_pop;
  ltd_pkg::token_t front_token;
  ltd_pkg::token_t q_token;

  ltd_front #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .MAX_MATCH_LENGTH (MAX_MATCH_LENGTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .match_position_i (match_position_i),
    .match_length_i   (match_length_i),
    .literal_byte_i   (literal_byte_i),
    .push_o           (push),
    .full_i           (full),
    .token_o          (front_token)
  );

  ltd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (front_token),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .token_o (q_token)
  );

  ltd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_token_i       (q_token),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_of_token_o (last_of_token_o)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lz77_token_decoder_unit. A shadow history and
// write pointer predict every decoded byte from each accepted request, and a
// checker compares the byte stream against them. Directed tokens, several
// random phases with sender gaps and receiver stalls, a long receiver
// hold-off, and a pass over a fully written, wrapped history are run.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned POS_W     = ltd_pkg::POS_W;
  localparam int unsigned LEN_W     = ltd_pkg::LEN_W;
  localparam int unsigned BYTE_W    = ltd_pkg::BYTE_W;
  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned MAX_LEN   = 63;
  localparam int unsigned SETTLE    = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_rec_t;

  logic              clk_i          = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [POS_W-1:0]  match_position = '0;
  logic [LEN_W-1:0]  match_length   = '0;
  logic [BYTE_W-1:0] literal_byte   = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_token;

  // Shadow of the decoder state. The default depth equals 2**POS_W, so the
  // pointer arithmetic wraps on its own.
  logic [BYTE_W-1:0] hist_mem [DEPTH];
  bit                hist_written [DEPTH];
  logic [POS_W-1:0]  wr_ptr = '0;
  int unsigned       filled = 0;

  out_rec_t          pending_bytes [$];
  int unsigned       mismatches     = 0;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       hold_left      = 0;

  lz77_token_decoder_unit #(
    .HISTORY_DEPTH    (DEPTH),
    .MAX_MATCH_LENGTH (MAX_LEN)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .match_position_i (match_position),
    .match_length_i   (match_length),
    .literal_byte_i   (literal_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_byte_o       (out_byte),
    .last_of_token_o  (last_of_token)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk_i) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void append_byte(logic [BYTE_W-1:0] b, logic last);
    hist_mem[wr_ptr] = b;
    if (!hist_written[wr_ptr]) begin
      hist_written[wr_ptr] = 1'b1;
      filled++;
    end
    wr_ptr = wr_ptr + 1'b1;
    pending_bytes.push_back('{data: b, last: last});
  endfunction

  // Copied bytes are written back one at a time, so a copy can read what it
  // has just produced.
  function automatic void predict_token(logic [POS_W-1:0] pos, logic [LEN_W-1:0] len,
                                        logic [BYTE_W-1:0] lit);
    int unsigned n;
    logic [POS_W-1:0] rd;
    n = (len > MAX_LEN) ? MAX_LEN : len;
    for (int unsigned i = 0; i < n; i++) begin
      rd = pos + POS_W'(i);
      append_byte(hist_mem[rd], 1'b0);
    end
    append_byte(lit, 1'b1);
  endfunction

  // True when every entry the copy reads is written, either earlier or by
  // the copy itself before the read.
  function automatic bit copy_is_defined(logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
    int unsigned n;
    logic [POS_W-1:0] rd;
    logic [POS_W-1:0] ahead;
    n = (len > MAX_LEN) ? MAX_LEN : len;
    for (int unsigned i = 0; i < n; i++) begin
      rd = pos + POS_W'(i);
      ahead = rd - wr_ptr;
      if (!hist_written[rd] && ahead >= POS_W'(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic pick_token(output logic [POS_W-1:0] pos, output logic [LEN_W-1:0] len,
                            output logic [BYTE_W-1:0] lit);
    int unsigned kind;
    int unsigned gap;
    lit = BYTE_W'($urandom_range(255));
    for (int unsigned tries = 0; tries < 20; tries++) begin
      kind = $urandom_range(99);
      len  = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(1, 4))
                                      : LEN_W'($urandom_range(1, MAX_LEN));
      if (kind < 12 || filled == 0) break;
      if (kind < 30) gap = $urandom_range(1, 4);
      else if (kind < 75) gap = $urandom_range(1, filled);
      else gap = $urandom_range(1, DEPTH);
      pos = wr_ptr - POS_W'(gap);
      if (copy_is_defined(pos, len)) return;
    end
    // Literal only; the position is ignored and may take any value.
    pos = POS_W'($urandom);
    len = '0;
  endtask

  // Offers one request, starting and ending at a falling edge.
  task automatic send_token(input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len,
                            input logic [BYTE_W-1:0] lit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid       <= 1'b1;
    match_position <= pos;
    match_length   <= len;
    literal_byte   <= lit;
    do @(posedge clk_i); while (in_stall);
    predict_token(pos, len, lit);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_output
    out_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("out_byte: expected nothing, actual 0x%02h", out_byte);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, out_byte);
          mismatches++;
        end
        if (last_of_token !== want.last) begin
          $error("last_of_token: expected %0b, actual %0b", want.last, last_of_token);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_token(12'h000, 6'd0, 8'h00);
    send_token(12'hFFF, 6'd0, 8'hFF);
    send_token(12'hAAA, 6'd0, 8'hA5);
    send_token(12'h555, 6'd0, 8'h5A);
    send_token(12'h000, 6'd3, 8'h11);
    // Distance one: the copy repeats the last byte for the whole length.
    send_token(wr_ptr - 12'd1, 6'd63, 8'h22);
    send_token(wr_ptr - 12'd2, 6'd10, 8'h33);
    send_token(12'h000, 6'd63, 8'h44);
    send_token(12'h001, 6'd1, 8'h80);
    send_token(12'h004, 6'd32, 8'h7F);
    send_token(wr_ptr - 12'd3, 6'd16, 8'h01);
    send_token(wr_ptr - 12'd40, 6'd2, 8'hFE);
  endtask

  task automatic test_random_tokens(input int unsigned count, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] lit;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      pick_token(pos, len, lit);
      send_token(pos, len, lit);
    end
  endtask

  // The receiver holds off long enough for the front queue to fill, so the
  // input must stall while requests keep coming.
  task automatic test_backpressure();
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] lit;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    repeat (12) begin
      pick_token(pos, len, lit);
      send_token(pos, len, lit);
    end
  endtask

  task automatic test_wrap_and_ahead();
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    while (filled < DEPTH) send_token(wr_ptr - 12'd1, 6'd63, BYTE_W'($urandom));
    // Read index crosses the top of the history.
    send_token(12'hFFF, 6'd63, 8'hC3);
    // Start at the write pointer: the entry about to be overwritten is read.
    send_token(wr_ptr, 6'd20, 8'h3C);
    // Start ahead of the write pointer; the copy never catches up.
    send_token(wr_ptr + 12'd5, 6'd40, 8'h96);
    send_token(wr_ptr + 12'd2048, 6'd63, 8'h69);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_tokens(90, 0, 0);
    test_random_tokens(90, 53, 0);
    test_random_tokens(90, 0, 53);
    test_random_tokens(80, 7, 7);
    test_backpressure();
    test_wrap_and_ahead();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
